[hw/rtl/tlptw_pkg.sv]
// Shared types and constants for the two-level page table walk.
// Holds the channel payload structs, the queue entry, config and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlptw_pkg;

   // index field width carried through the queue
   localparam int unsigned IDX_W = 12;

   // result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_OOB    = 2'd1;
   localparam logic [1:0] ST_POOL   = 2'd2;
   localparam logic [1:0] ST_WIDTHS = 2'd3;

   // config register indexes
   localparam logic [2:0] CSR_DIR_BITS     = 3'd0;
   localparam logic [2:0] CSR_SL_BITS      = 3'd1;
   localparam logic [2:0] CSR_OFFSET_BITS  = 3'd2;
   localparam logic [2:0] CSR_WINDOW_START = 3'd3;
   localparam logic [2:0] CSR_WINDOW_END   = 3'd4;

   // config reset values
   localparam logic [3:0]  RST_DIR_BITS     = 4'd10;
   localparam logic [3:0]  RST_SL_BITS      = 4'd10;
   localparam logic [4:0]  RST_OFFSET_BITS  = 5'd12;
   localparam logic [31:0] RST_WINDOW_START = 32'd0;
   localparam logic [31:0] RST_WINDOW_END   = 32'd1048575;

   // action code
   localparam logic ACT_WRITE = 1'b1;

   // queue depth between front and back
   localparam int unsigned Q_DEPTH = 2;

   typedef struct packed {
      logic        action;
      logic [31:0] vaddr;
      logic [31:0] new_frame_address;
      logic [31:0] new_protection;
   } req_type;

   typedef struct packed {
      logic [31:0] frame_address;
      logic [31:0] protection;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  directory_bits;
      logic [3:0]  second_level_bits;
      logic [4:0]  offset_bits;
      logic [31:0] window_start;
      logic [31:0] window_end;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic             is_write;
      logic [1:0]       status;
      logic [IDX_W-1:0] l1_index;
      logic [IDX_W-1:0] l2_index;
      logic [31:0]      new_frame_address;
      logic [31:0]      new_protection;
   } qent_type;

endpackage

`default_nettype wire

[hw/rtl/tlptw_front.sv]
// Front end: accepts request items, checks field widths and the read window,
// and splits the address into directory and second-level indexes.
// Depends on tlptw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlptw_front #(
   parameter int unsigned MAX_DIRECTORY_BITS    = 10,
   parameter int unsigned MAX_SECOND_LEVEL_BITS = 10
) (
   input  wire                    req_valid,
   output logic                   req_ready,
   input  tlptw_pkg::req_type     req_data,
   input  tlptw_pkg::cfg_type     cfg,
   input  wire                    clearing,
   output logic                   push_valid,
   input  wire                    push_ready,
   output tlptw_pkg::qent_type    push_data
);
   import tlptw_pkg::*;

   logic        widths_ok;
   logic        out_of_window;
   logic [5:0]  width_sum;
   logic [5:0]  hi_shift;
   logic [31:0] sl_mask;
   logic [31:0] sl_field;
   logic [31:0] dir_field;

   // check the configured field widths
   assign width_sum = 6'(cfg.directory_bits) + 6'(cfg.second_level_bits)
                    + 6'(cfg.offset_bits);
   assign widths_ok = (cfg.directory_bits != 4'd0) && (cfg.second_level_bits != 4'd0)
                   && (cfg.offset_bits != 5'd0)
                   && (cfg.directory_bits <= 4'(MAX_DIRECTORY_BITS))
                   && (cfg.second_level_bits <= 4'(MAX_SECOND_LEVEL_BITS))
                   && (width_sum == 6'd32);

   // reads must fall inside the window; writes are not checked
   assign out_of_window = (req_data.action != ACT_WRITE)
                       && ((req_data.vaddr < cfg.window_start)
                        || (req_data.vaddr > cfg.window_end));

   // split the address
   assign hi_shift  = 6'(cfg.offset_bits) + 6'(cfg.second_level_bits);
   assign sl_mask   = (32'd1 << cfg.second_level_bits) - 32'd1;
   assign sl_field  = (req_data.vaddr >> cfg.offset_bits) & sl_mask;
   assign dir_field = req_data.vaddr >> hi_shift;

   // classify and hand over
   always_comb begin
      push_data.is_write          = (req_data.action == ACT_WRITE);
      push_data.l1_index          = dir_field[IDX_W-1:0];
      push_data.l2_index          = sl_field[IDX_W-1:0];
      push_data.new_frame_address = req_data.new_frame_address;
      push_data.new_protection    = req_data.new_protection;
      if (!widths_ok) begin
         push_data.status = ST_WIDTHS;
      end else if (out_of_window) begin
         push_data.status = ST_OOB;
      end else begin
         push_data.status = ST_OK;
      end
   end

   // hold off items while the directory is being cleared
   assign push_valid = req_valid && !clearing;
   assign req_ready  = push_ready && !clearing;

endmodule

`default_nettype wire

[hw/rtl/tlptw_queue.sv]
// Short FIFO between the front end and the walk engine.
// Holds classified items so either side can stall on its own.
// Depends on tlptw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlptw_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push_valid,
   output logic                   push_ready,
   input  tlptw_pkg::qent_type    push_data,
   output logic                   pop_valid,
   input  wire                    pop,
   output tlptw_pkg::qent_type    pop_data
);
   import tlptw_pkg::*;

   localparam int unsigned PW = $clog2(Q_DEPTH);
   localparam int unsigned CNTW = $clog2(Q_DEPTH + 1);

   qent_type        slot_ff [Q_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != CNTW'(Q_DEPTH));
   assign pop_valid  = (count_ff != CNTW'(0));
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(Q_DEPTH - 1)) ? PW'(0) : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(Q_DEPTH - 1)) ? PW'(0) : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/tlptw_back.sv]
// Walk engine: looks up the directory, allocates and clears second-level
// tables from the pool, and reads or writes entries. Owns the result register.
// Depends on tlptw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlptw_back #(
   parameter int unsigned MAX_DIRECTORY_BITS    = 10,
   parameter int unsigned MAX_SECOND_LEVEL_BITS = 10,
   parameter int unsigned POOL_TABLES           = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    q_valid,
   input  tlptw_pkg::qent_type    q_head,
   output logic                   q_pop,
   output logic                   clearing,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output tlptw_pkg::rsp_type     rsp_data
);
   import tlptw_pkg::*;

   localparam int unsigned DW        = MAX_DIRECTORY_BITS;
   localparam int unsigned SW        = MAX_SECOND_LEVEL_BITS;
   localparam int unsigned TW        = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
   localparam int unsigned CW        = $clog2(POOL_TABLES + 1);
   localparam int unsigned DIR_DEPTH = 2 ** DW;
   localparam int unsigned ENT_DEPTH = POOL_TABLES * (2 ** SW);
   localparam int unsigned EAW       = $clog2(ENT_DEPTH);

   // walk states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DIR   = 3'd2;
   localparam logic [2:0] S_FILL  = 3'd3;
   localparam logic [2:0] S_ENTRY = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   // directory entry: present bit over table number
   logic [TW:0]     dir_mem [DIR_DEPTH];
   logic [63:0]     ent_mem [ENT_DEPTH];

   logic [2:0]      state_ff, state_in;
   logic [DW-1:0]   clr_ff, clr_in;
   logic [SW-1:0]   fill_ff, fill_in;
   logic [CW-1:0]   alloc_ff, alloc_in;
   logic [TW-1:0]   tnum_ff, tnum_in;
   qent_type        cur_ff, cur_in;
   rsp_type         res_ff, res_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [TW:0]     dir_rd_ff;
   logic [63:0]     ent_rd_ff;

   logic            dir_we;
   logic [DW-1:0]   dir_waddr;
   logic [TW:0]     dir_wdata;
   logic [DW-1:0]   dir_raddr;
   logic            ent_we;
   logic [EAW-1:0]  ent_waddr;
   logic [63:0]     ent_wdata;
   logic [EAW-1:0]  ent_raddr;

   logic [DW-1:0]   cur_l1;
   logic [SW-1:0]   cur_l2;
   logic            pool_full;
   logic            out_free;

   assign cur_l1    = cur_ff.l1_index[DW-1:0];
   assign cur_l2    = cur_ff.l2_index[SW-1:0];
   assign pool_full = (alloc_ff == CW'(POOL_TABLES));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign dir_raddr = q_head.l1_index[DW-1:0];
   assign ent_raddr = EAW'({dir_rd_ff[TW-1:0], cur_l2});

   assign clearing  = (state_ff == S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // walk sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      fill_in      = fill_ff;
      alloc_in     = alloc_ff;
      tnum_in      = tnum_ff;
      cur_in       = cur_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop        = 1'b0;
      dir_we       = 1'b0;
      dir_waddr    = clr_ff;
      dir_wdata    = '0;
      ent_we       = 1'b0;
      ent_waddr    = EAW'({dir_rd_ff[TW-1:0], cur_l2});
      ent_wdata    = {cur_ff.new_frame_address, cur_ff.new_protection};

      unique case (state_ff)
         S_CLEAR: begin
            // sweep the directory to not-present after reset
            dir_we = 1'b1;
            clr_in = clr_ff + DW'(1);
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // take the next item; directory read is issued on its index
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               if (q_head.status != ST_OK) begin
                  res_in.frame_address = '0;
                  res_in.protection    = '0;
                  res_in.status        = q_head.status;
                  state_in             = S_RESP;
               end else begin
                  state_in = S_DIR;
               end
            end
         end
         S_DIR: begin
            res_in.frame_address = '0;
            res_in.protection    = '0;
            res_in.status        = ST_OK;
            if (dir_rd_ff[TW]) begin
               // table present: write now or issue the entry read
               if (cur_ff.is_write) begin
                  ent_we   = 1'b1;
                  state_in = S_RESP;
               end else begin
                  state_in = S_ENTRY;
               end
            end else if (pool_full) begin
               res_in.status = ST_POOL;
               state_in      = S_RESP;
            end else begin
               // allocate the next table and bind it to the slot
               dir_we    = 1'b1;
               dir_waddr = cur_l1;
               dir_wdata = {1'b1, TW'(alloc_ff)};
               tnum_in   = TW'(alloc_ff);
               alloc_in  = alloc_ff + CW'(1);
               fill_in   = '0;
               state_in  = S_FILL;
            end
         end
         S_FILL: begin
            // clear the new row to all ones, dropping the write data in on its entry
            ent_we    = 1'b1;
            ent_waddr = EAW'({tnum_ff, fill_ff});
            if (!(cur_ff.is_write && (fill_ff == cur_l2))) begin
               ent_wdata = '1;
            end
            fill_in = fill_ff + SW'(1);
            if (&fill_ff) begin
               res_in.frame_address = cur_ff.is_write ? '0 : '1;
               res_in.protection    = cur_ff.is_write ? '0 : '1;
               res_in.status        = ST_OK;
               state_in             = S_RESP;
            end
         end
         S_ENTRY: begin
            res_in.frame_address = ent_rd_ff[63:32];
            res_in.protection    = ent_rd_ff[31:0];
            res_in.status        = ST_OK;
            state_in             = S_RESP;
         end
         S_RESP: begin
            // hand the result to the output register once it is free
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         alloc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fill_ff <= fill_in;
      tnum_ff <= tnum_in;
      cur_ff  <= cur_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   // directory memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      dir_rd_ff <= dir_mem[dir_raddr];
   end

   // entry store: one write, one registered read
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_rd_ff <= ent_mem[ent_raddr];
   end

   // the pool count never runs past the pool
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      alloc_ff <= CW'(POOL_TABLES))
      else $error("table pool count exceeds pool size");

   // only items that passed the front checks reach a row clear
   a_fill_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> (cur_ff.status == ST_OK))
      else $error("row clear started for a rejected item");

   // each allocation takes exactly one table
   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIR && state_in == S_FILL) |=> (alloc_ff == $past(alloc_ff) + CW'(1)))
      else $error("allocation did not advance the pool count by one");

   // a read into a freshly cleared table returns the invalid pattern
   a_fresh_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL && state_in == S_RESP && !cur_ff.is_write)
      |=> (res_ff.frame_address == '1 && res_ff.protection == '1))
      else $error("read after allocation did not return all ones");

endmodule

`default_nettype wire

[hw/rtl/two_level_page_table_walk.sv]
// Top level of the two-level page table walk: config registers, front end,
// item queue and walk engine.
// Depends on tlptw_pkg, tlptw_front, tlptw_queue, tlptw_back.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   tlptw_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready   tlptw_pkg::rsp_type
//   csr      in         csr_we (no wait)      csr_index, csr_wdata
//
// Walk engine steps per item: a rejected item goes straight to the result; a write to an
// existing table takes the directory read, then the write; a read of one takes the
// directory read, then the entry read. An item that allocates a table clears the new
// row one entry at a time, dropping the write data in on its entry.
// After reset the directory is swept to not-present with req_ready low;
// config writes are taken throughout.
// A two-entry queue lets requests be taken while the engine or rsp is stalled.
`timescale 1ns / 1ps
`default_nettype none

module two_level_page_table_walk #(
   parameter int unsigned MAX_DIRECTORY_BITS    = 10,
   parameter int unsigned MAX_SECOND_LEVEL_BITS = 10,
   parameter int unsigned POOL_TABLES           = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  tlptw_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output tlptw_pkg::rsp_type   rsp_data,
   input  wire                  csr_we,
   input  wire [2:0]            csr_index,
   input  wire [31:0]           csr_wdata
);
   import tlptw_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     clearing;
   logic     push_valid;
   logic     push_ready;
   qent_type push_data;
   logic     q_valid;
   logic     q_pop;
   qent_type q_head;

   // config register writes, masked to each register's width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DIR_BITS:     cfg_in.directory_bits    = csr_wdata[3:0];
            CSR_SL_BITS:      cfg_in.second_level_bits = csr_wdata[3:0];
            CSR_OFFSET_BITS:  cfg_in.offset_bits       = csr_wdata[4:0];
            CSR_WINDOW_START: cfg_in.window_start      = csr_wdata;
            CSR_WINDOW_END:   cfg_in.window_end        = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.directory_bits    <= RST_DIR_BITS;
         cfg_ff.second_level_bits <= RST_SL_BITS;
         cfg_ff.offset_bits       <= RST_OFFSET_BITS;
         cfg_ff.window_start      <= RST_WINDOW_START;
         cfg_ff.window_end        <= RST_WINDOW_END;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tlptw_front #(
      .MAX_DIRECTORY_BITS    (MAX_DIRECTORY_BITS),
      .MAX_SECOND_LEVEL_BITS (MAX_SECOND_LEVEL_BITS)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .clearing   (clearing),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   tlptw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_head)
   );

   tlptw_back #(
      .MAX_DIRECTORY_BITS    (MAX_DIRECTORY_BITS),
      .MAX_SECOND_LEVEL_BITS (MAX_SECOND_LEVEL_BITS),
      .POOL_TABLES           (POOL_TABLES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[dv/two_level_page_table_walk_tb.sv]
// Self-checking testbench for two_level_page_table_walk: a directed table, then random
// walks over several field-width and window settings, checked against an in-bench model.
// Depends on tlptw_pkg and the two_level_page_table_walk RTL.
`timescale 1ns / 1ps

module two_level_page_table_walk_tb;
   import tlptw_pkg::*;

   localparam int unsigned MAX_DIR_BITS    = 10;
   localparam int unsigned MAX_SL_BITS     = 10;
   localparam int unsigned POOL_LEN        = 16;
   localparam int unsigned DIR_SLOTS       = 1 << MAX_DIR_BITS;
   localparam int unsigned ROW_LEN         = 1 << MAX_SL_BITS;
   localparam logic        ACT_READ        = 1'b0;
   localparam logic [2:0]  CSR_UNUSED      = 3'd7;
   localparam logic [31:0] ONES            = 32'hFFFF_FFFF;
   localparam int unsigned NUM_PHASES      = 8;
   localparam int unsigned HOLD_OFF_AT     = 60;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned DRAIN_PAUSE     = 8;
   localparam int unsigned TAIL_CYCLES     = 20;

   typedef enum logic {ROW_ITEM, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   reg_index;
      logic [31:0]  reg_value;
      req_type      item;
      logic         typed;
      rsp_type      want;
   } stim_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic        csr_we    = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // model copy of the registers
   logic [3:0]  dir_bits_m;
   logic [3:0]  sl_bits_m;
   logic [4:0]  off_bits_m;
   logic [31:0] win_lo;
   logic [31:0] win_hi;

   // model copy of the tables
   bit          slot_present [DIR_SLOTS];
   int unsigned slot_table   [DIR_SLOTS];
   int unsigned tables_used;
   logic [31:0] entry_frame  [POOL_LEN*ROW_LEN];
   logic [31:0] entry_prot   [POOL_LEN*ROW_LEN];
   int unsigned alloc_slots[$];
   logic [31:0] written_vas[$];

   rsp_type      pending_walks[$];
   stim_row_type directed_rows[$];
   cfg_type      phase_cfg [NUM_PHASES];
   int unsigned  phase_len [NUM_PHASES];
   int unsigned  n_sent       = 0;
   int unsigned  n_walks_seen = 0;
   int unsigned  n_mismatches = 0;

   always #2 clock = ~clock;

   two_level_page_table_walk #(
      .MAX_DIRECTORY_BITS   (MAX_DIR_BITS),
      .MAX_SECOND_LEVEL_BITS(MAX_SL_BITS),
      .POOL_TABLES          (POOL_LEN)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   function automatic bit widths_valid();
      int unsigned d, s, o;
      d = dir_bits_m;
      s = sl_bits_m;
      o = off_bits_m;
      return d != 0 && s != 0 && o != 0 && d <= MAX_DIR_BITS && s <= MAX_SL_BITS
             && d + s + o == 32;
   endfunction

   function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
         CSR_DIR_BITS:     dir_bits_m = val[3:0];
         CSR_SL_BITS:      sl_bits_m  = val[3:0];
         CSR_OFFSET_BITS:  off_bits_m = val[4:0];
         CSR_WINDOW_START: win_lo     = val;
         CSR_WINDOW_END:   win_hi     = val;
         default: ;
      endcase
   endfunction

   // Walk one request through the model tables and return its result
   function automatic rsp_type predict_walk(req_type r);
      rsp_type     res;
      int unsigned s, o, l1, l2, pos, i;
      res = '0;
      res.status = ST_OK;
      s = sl_bits_m;
      o = off_bits_m;
      if (!widths_valid()) begin
         res.status = ST_WIDTHS;
      end else if (r.action != ACT_WRITE &&
                   (r.vaddr < win_lo || r.vaddr > win_hi)) begin
         res.status = ST_OOB;
      end else begin
         l2 = (r.vaddr >> o) & ((1 << s) - 1);
         l1 = (r.vaddr >> (o + s)) & (DIR_SLOTS - 1);
         if (!slot_present[l1] && tables_used >= POOL_LEN) begin
            res.status = ST_POOL;
         end else begin
            // first touch: bind the next pool table and mark every entry invalid
            if (!slot_present[l1]) begin
               slot_present[l1] = 1'b1;
               slot_table[l1]   = tables_used;
               for (i = 0; i < ROW_LEN; i++) begin
                  entry_frame[tables_used*ROW_LEN + i] = ONES;
                  entry_prot[tables_used*ROW_LEN + i]  = ONES;
               end
               tables_used++;
               alloc_slots.push_back(l1);
            end
            pos = slot_table[l1]*ROW_LEN + l2;
            if (r.action == ACT_WRITE) begin
               entry_frame[pos] = r.new_frame_address;
               entry_prot[pos]  = r.new_protection;
            end else begin
               res.frame_address = entry_frame[pos];
               res.protection    = entry_prot[pos];
            end
         end
      end
      return res;
   endfunction

   // Random request: mostly walks into tables already bound, some fresh slots, some noise
   function automatic req_type make_access();
      req_type     it;
      int unsigned dir_w, sl_w, off_w, slot, sub;
      int unsigned fits[$];
      logic [63:0] off_mask;
      it.action            = ($urandom_range(0, 1) == 1) ? ACT_WRITE : ACT_READ;
      it.new_frame_address = $urandom();
      it.new_protection    = $urandom();
      dir_w    = dir_bits_m;
      sl_w     = sl_bits_m;
      off_w    = off_bits_m;
      off_mask = (64'd1 << off_w) - 1;
      if (!widths_valid() || $urandom_range(0, 99) < 15) begin
         it.vaddr = $urandom();
      end else if (written_vas.size() != 0 && $urandom_range(0, 99) < 35) begin
         // revisit a mapped entry with a fresh offset
         it.vaddr = (written_vas[$urandom_range(0, written_vas.size() - 1)]
                     & ~off_mask[31:0]) | ($urandom() & off_mask[31:0]);
      end else begin
         foreach (alloc_slots[i]) begin
            if (alloc_slots[i] < (1 << dir_w)) fits.push_back(alloc_slots[i]);
         end
         if (fits.size() != 0 && $urandom_range(0, 99) < 85)
            slot = fits[$urandom_range(0, fits.size() - 1)];
         else
            slot = $urandom_range(0, (1 << dir_w) - 1);
         sub = $urandom_range(0, (1 << sl_w) - 1);
         it.vaddr = 32'((64'(slot) << (off_w + sl_w)) | (64'(sub) << off_w)
                        | (64'($urandom()) & off_mask));
         if (it.action == ACT_WRITE) begin
            written_vas.push_back(it.vaddr);
            if (written_vas.size() > 16) void'(written_vas.pop_front());
         end
      end
      return it;
   endfunction

   function automatic stim_row_type item_row(logic act, logic [31:0] va, logic [31:0] nf,
                                             logic [31:0] np, logic typed, logic [31:0] frame,
                                             logic [31:0] prot, logic [1:0] st);
      stim_row_type row;
      row = '0;
      row.kind                   = ROW_ITEM;
      row.item.action            = act;
      row.item.vaddr             = va;
      row.item.new_frame_address = nf;
      row.item.new_protection    = np;
      row.typed                  = typed;
      row.want.frame_address     = frame;
      row.want.protection        = prot;
      row.want.status            = st;
      return row;
   endfunction

   function automatic stim_row_type reg_row(logic [2:0] idx, logic [31:0] val);
      stim_row_type row;
      row = '0;
      row.kind      = ROW_REG;
      row.reg_index = idx;
      row.reg_value = val;
      return row;
   endfunction

   // Offer one item after a random gap, hold it until taken, then queue its result
   task automatic send_item(req_type it, logic typed, rsp_type want);
      int unsigned gap;
      rsp_type     got;
      gap = (((n_sent / 32) % 4) == 3) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = predict_walk(it);
      pending_walks.push_back(typed ? want : got);
      n_sent++;
   endtask

   // Drop valid and wait for every outstanding result
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_walks.size() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: random stalls, one long hold-off, and check each item in order
   initial begin : result_side
      int unsigned stall;
      rsp_type     want;
      // hold until reset is released so rsp_valid is known
      wait (!reset);
      forever begin
         if (n_walks_seen == HOLD_OFF_AT)
            stall = HOLD_OFF_CYCLES;
         else if (((n_walks_seen / 40) % 4) == 2)
            stall = 0;
         else
            stall = $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         n_walks_seen++;
         if (pending_walks.size() == 0) begin
            $error("unexpected result: frame %h prot %h status %0d",
                   rsp_data.frame_address, rsp_data.protection, rsp_data.status);
            n_mismatches++;
         end else begin
            want = pending_walks.pop_front();
            if (rsp_data.frame_address !== want.frame_address) begin
               $error("frame_address: expected %h, got %h",
                      want.frame_address, rsp_data.frame_address);
               n_mismatches++;
            end
            if (rsp_data.protection !== want.protection) begin
               $error("protection: expected %h, got %h", want.protection, rsp_data.protection);
               n_mismatches++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               n_mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      rsp_type     nothing;
      req_type     it;
      int unsigned p, k;
      nothing    = '0;
      dir_bits_m = RST_DIR_BITS;
      sl_bits_m  = RST_SL_BITS;
      off_bits_m = RST_OFFSET_BITS;
      win_lo     = RST_WINDOW_START;
      win_hi     = RST_WINDOW_END;
      for (k = 0; k < DIR_SLOTS; k++) slot_present[k] = 1'b0;
      tables_used = 0;

      // reset widths and window: first touch, window edges, unchecked writes
      directed_rows.push_back(item_row(ACT_READ, 32'h0, 32'h0, 32'h0, 1'b1, ONES, ONES, ST_OK));
      directed_rows.push_back(item_row(ACT_READ, 32'h000F_FFFF, 32'h0, 32'h0, 1'b1,
                                       ONES, ONES, ST_OK));
      directed_rows.push_back(item_row(ACT_READ, 32'h0010_0000, 32'h0, 32'h0, 1'b1,
                                       32'h0, 32'h0, ST_OOB));
      directed_rows.push_back(item_row(ACT_WRITE, ONES, ONES, ONES, 1'b1, 32'h0, 32'h0, ST_OK));
      directed_rows.push_back(item_row(ACT_READ, ONES, 32'h0, 32'h0, 1'b1,
                                       32'h0, 32'h0, ST_OOB));
      directed_rows.push_back(item_row(ACT_WRITE, 32'h0, ONES, 32'h0, 1'b1,
                                       32'h0, 32'h0, ST_OK));
      directed_rows.push_back(item_row(ACT_READ, 32'h0000_0FFF, 32'h0, 32'h0, 1'b1,
                                       ONES, 32'h0, ST_OK));
      directed_rows.push_back(item_row(ACT_WRITE, 32'h0000_1000, 32'h0, ONES, 1'b1,
                                       32'h0, 32'h0, ST_OK));
      directed_rows.push_back(item_row(ACT_READ, 32'h0000_1FFF, 32'h0, 32'h0, 1'b1,
                                       32'h0, ONES, ST_OK));
      // window pinned to the top address
      directed_rows.push_back(reg_row(CSR_WINDOW_END, ONES));
      directed_rows.push_back(reg_row(CSR_WINDOW_START, ONES));
      directed_rows.push_back(item_row(ACT_READ, ONES, 32'h0, 32'h0, 1'b1, ONES, ONES, ST_OK));
      directed_rows.push_back(item_row(ACT_READ, 32'hFFFF_FFFE, 32'h0, 32'h0, 1'b1,
                                       32'h0, 32'h0, ST_OOB));
      // start above end: every read out of bounds, writes still land
      directed_rows.push_back(reg_row(CSR_WINDOW_START, 32'h10));
      directed_rows.push_back(reg_row(CSR_WINDOW_END, 32'h0F));
      directed_rows.push_back(item_row(ACT_READ, 32'h10, 32'h0, 32'h0, 1'b1,
                                       32'h0, 32'h0, ST_OOB));
      directed_rows.push_back(item_row(ACT_READ, 32'h0F, 32'h0, 32'h0, 1'b1,
                                       32'h0, 32'h0, ST_OOB));
      directed_rows.push_back(item_row(ACT_WRITE, 32'h10, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1,
                                       32'h0, 32'h0, ST_OK));
      directed_rows.push_back(reg_row(CSR_WINDOW_START, 32'h0));
      directed_rows.push_back(reg_row(CSR_WINDOW_END, ONES));
      // bad widths: zero field, directory over max, second level over max
      directed_rows.push_back(reg_row(CSR_DIR_BITS, 32'd0));
      directed_rows.push_back(item_row(ACT_READ, 32'h0, 32'h0, 32'h0, 1'b1,
                                       32'h0, 32'h0, ST_WIDTHS));
      directed_rows.push_back(item_row(ACT_WRITE, 32'h0040_0000, ONES, ONES, 1'b1,
                                       32'h0, 32'h0, ST_WIDTHS));
      directed_rows.push_back(reg_row(CSR_DIR_BITS, 32'd11));
      directed_rows.push_back(reg_row(CSR_SL_BITS, 32'd9));
      directed_rows.push_back(item_row(ACT_READ, 32'h0, 32'h0, 32'h0, 1'b1,
                                       32'h0, 32'h0, ST_WIDTHS));
      directed_rows.push_back(reg_row(CSR_DIR_BITS, 32'd9));
      directed_rows.push_back(reg_row(CSR_SL_BITS, 32'd11));
      directed_rows.push_back(item_row(ACT_READ, 32'h0, 32'h0, 32'h0, 1'b1,
                                       32'h0, 32'h0, ST_WIDTHS));
      // narrowest index fields, written with junk above each register's width
      directed_rows.push_back(reg_row(CSR_DIR_BITS, 32'hFFFF_FFF1));
      directed_rows.push_back(reg_row(CSR_SL_BITS, 32'hFFFF_FFE1));
      directed_rows.push_back(reg_row(CSR_OFFSET_BITS, 32'hFFFF_FFFE));
      directed_rows.push_back(item_row(ACT_READ, 32'hC000_0000, 32'h0, 32'h0, 1'b1,
                                       ONES, ONES, ST_OK));
      directed_rows.push_back(item_row(ACT_WRITE, 32'h4000_0000, 32'hA5A5_5A5A, 32'h0F0F_F0F0,
                                       1'b0, 32'h0, 32'h0, ST_OK));
      directed_rows.push_back(item_row(ACT_READ, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0,
                                       32'h0, 32'h0, ST_OK));
      // index past the register list leaves everything alone
      directed_rows.push_back(reg_row(CSR_UNUSED, 32'h0));
      directed_rows.push_back(item_row(ACT_READ, 32'h4000_0000, 32'h0, 32'h0, 1'b0,
                                       32'h0, 32'h0, ST_OK));
      // widths that do not sum to 32, then widths changed under bound tables
      directed_rows.push_back(reg_row(CSR_SL_BITS, 32'd10));
      directed_rows.push_back(item_row(ACT_READ, 32'h0, 32'h0, 32'h0, 1'b1,
                                       32'h0, 32'h0, ST_WIDTHS));
      directed_rows.push_back(reg_row(CSR_OFFSET_BITS, 32'd21));
      directed_rows.push_back(item_row(ACT_READ, 32'h0020_0000, 32'h0, 32'h0, 1'b0,
                                       32'h0, 32'h0, ST_OK));
      directed_rows.push_back(reg_row(CSR_OFFSET_BITS, 32'd31));
      directed_rows.push_back(item_row(ACT_READ, 32'h0, 32'h0, 32'h0, 1'b1,
                                       32'h0, 32'h0, ST_WIDTHS));
      directed_rows.push_back(reg_row(CSR_DIR_BITS, 32'd10));
      directed_rows.push_back(reg_row(CSR_SL_BITS, 32'd10));
      directed_rows.push_back(reg_row(CSR_OFFSET_BITS, 32'd12));
      directed_rows.push_back(item_row(ACT_READ, 32'h0000_1000, 32'h0, 32'h0, 1'b0,
                                       32'h0, 32'h0, ST_OK));

      // random phases: widths, window and length of each
      phase_cfg[0] = '{4'd10, 4'd10, 5'd12, 32'h0000_0000, 32'hFFFF_FFFF};
      phase_cfg[1] = '{4'd1,  4'd1,  5'd30, 32'h0000_0000, 32'hFFFF_FFFF};
      phase_cfg[2] = '{4'd4,  4'd8,  5'd20, 32'h1000_0000, 32'h8FFF_FFFF};
      phase_cfg[3] = '{4'd10, 4'd1,  5'd21, 32'h0000_0000, 32'hFFFF_FFFF};
      phase_cfg[4] = '{4'd1,  4'd10, 5'd21, 32'h0000_0000, 32'h7FFF_FFFF};
      phase_cfg[5] = '{4'd3,  4'd3,  5'd3,  32'h0000_0000, 32'hFFFF_FFFF};
      phase_cfg[6] = '{4'd8,  4'd4,  5'd20, 32'hFFFF_FFFF, 32'h0000_0000};
      phase_cfg[7] = '{4'd10, 4'd10, 5'd12, 32'h0000_0000, 32'hFFFF_FFFF};
      phase_len = '{150, 130, 130, 130, 130, 20, 40, 200};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REG) begin
            settle();
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // random walks, one register setting per phase
      for (p = 0; p < NUM_PHASES; p++) begin
         settle();
         write_reg(CSR_DIR_BITS, ($urandom() << 4) | 32'(phase_cfg[p].directory_bits));
         write_reg(CSR_SL_BITS, ($urandom() << 4) | 32'(phase_cfg[p].second_level_bits));
         write_reg(CSR_OFFSET_BITS, ($urandom() << 5) | 32'(phase_cfg[p].offset_bits));
         write_reg(CSR_WINDOW_START, phase_cfg[p].window_start);
         write_reg(CSR_WINDOW_END, phase_cfg[p].window_end);
         for (k = 0; k < phase_len[p]; k++) begin
            it = make_access();
            send_item(it, 1'b0, nothing);
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (n_mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin : watchdog
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
